// File: design/msbr_pkg.sv
// ----------------------------------------------------------------------------
// msbr_pkg
// Shared types, codes and default sizes for the MSB-first bit reader.
// ----------------------------------------------------------------------------
package msbr_pkg;

    localparam int BUFFER_BYTES_DEF  = 256;
    localparam int MAX_READ_BITS_DEF = 64;

    typedef enum logic [2:0] {
        ACT_WRITE      = 3'd0,
        ACT_RESTART    = 3'd1,
        ACT_READ       = 3'd2,
        ACT_SKIP_BITS  = 3'd3,
        ACT_SKIP_BYTES = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_ARMED = 2'd1,
        ST_TOO_WIDE  = 2'd2,
        ST_BOUNDS    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_READ,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  write_address;
        logic [7:0]  write_byte;
        logic [8:0]  start_byte;
        logic [8:0]  region_size;
        logic [11:0] amount;
    } msbr_cmd_t;

    typedef struct packed {
        logic [63:0] bits_value;
        logic [8:0]  byte_index;
        logic [1:0]  status;
    } msbr_result_t;

    // Decision taken for one item, from the evaluation unit to the sequencer
    typedef struct packed {
        status_t status;
        logic    write_en;
        logic    restart;
        logic    pos_load;
        logic    read_go;
    } msbr_ctrl_t;

endpackage

// File: design/msbr_eval.sv
// ----------------------------------------------------------------------------
// msbr_eval
// Checks one item against the armed flag, the read width, the region end and,
// for a write, the buffer size; works out the bit position the item leaves.
// ----------------------------------------------------------------------------
module msbr_eval
    import msbr_pkg::*;
#(
    parameter int BUFFER_BYTES  = BUFFER_BYTES_DEF,
    parameter int MAX_READ_BITS = MAX_READ_BITS_DEF,
    parameter int POS_W         = 12
)
(
    input  msbr_cmd_t        cmd,
    input  logic [POS_W-1:0] pos,
    input  logic [8:0]       limit,
    input  logic             armed,
    output msbr_ctrl_t       ctrl,
    output logic [POS_W-1:0] new_pos
);

    localparam int EXT_W = POS_W + 4;

    logic [EXT_W-1:0] pos_x;
    logic [EXT_W-1:0] amt_x;
    logic [EXT_W-1:0] lim_x;
    logic [EXT_W-1:0] end_x;
    logic [EXT_W-1:0] bit_sum;
    logic [EXT_W-1:0] byte_next;
    logic [EXT_W-1:0] byte_end;

    always_comb
    begin
        pos_x = EXT_W'(pos);
        amt_x = EXT_W'(cmd.amount);
        lim_x = EXT_W'(limit);
        if (lim_x > EXT_W'(BUFFER_BYTES))
        begin
            lim_x = EXT_W'(BUFFER_BYTES);
        end
        end_x     = lim_x << 3;
        bit_sum   = pos_x + amt_x;
        // round up to a byte boundary, then add whole bytes
        byte_next = ((pos_x + EXT_W'(7)) >> 3) + amt_x;
        byte_end  = byte_next << 3;
    end

    always_comb
    begin
        ctrl     = '0;
        ctrl.status = ST_OK;
        new_pos  = pos;
        case (cmd.action)
            ACT_WRITE:
            begin
                ctrl.write_en = (32'(cmd.write_address) < 32'(BUFFER_BYTES));
            end
            ACT_RESTART:
            begin
                ctrl.restart  = 1'b1;
                ctrl.pos_load = 1'b1;
                new_pos       = POS_W'({cmd.start_byte, 3'b000});
            end
            ACT_READ:
            begin
                if (!armed)
                    ctrl.status = ST_NOT_ARMED;
                else if (amt_x > EXT_W'(MAX_READ_BITS))
                    ctrl.status = ST_TOO_WIDE;
                else if (bit_sum > end_x)
                    ctrl.status = ST_BOUNDS;
                else
                begin
                    ctrl.pos_load = 1'b1;
                    ctrl.read_go  = (cmd.amount != '0);
                    new_pos       = POS_W'(bit_sum);
                end
            end
            ACT_SKIP_BITS:
            begin
                if (!armed)
                    ctrl.status = ST_NOT_ARMED;
                else if (bit_sum > end_x)
                    ctrl.status = ST_BOUNDS;
                else
                begin
                    ctrl.pos_load = 1'b1;
                    new_pos       = POS_W'(bit_sum);
                end
            end
            ACT_SKIP_BYTES:
            begin
                if (!armed)
                    ctrl.status = ST_NOT_ARMED;
                else if (byte_end > end_x)
                    ctrl.status = ST_BOUNDS;
                else
                begin
                    ctrl.pos_load = 1'b1;
                    new_pos       = POS_W'(byte_end);
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

// File: design/msb_first_bit_reader.sv
// ----------------------------------------------------------------------------
// msb_first_bit_reader
// Byte buffer with an MSB-first bit reader: write, restart, read bits,
// skip bits and skip bytes, one result per item.
//
//   channel  | ports                 | handshake
//   ---------+-----------------------+-------------------------------------
//   command  | start, busy, cmd      | taken when start is high, busy low
//   result   | done, result          | valid for the single cycle done is high
//
// A read of n > 0 bits at bit offset o in its byte fetches
// ceil((o+n)/8) bytes (up to nine), one per cycle from the synchronous
// buffer port, in S_READ between S_EVAL and S_DONE; every other item
// goes from S_EVAL straight to S_DONE. busy is low only in S_IDLE, so
// a new item is taken only once the last is through. done rises in the
// last busy cycle. Reset clears position, region end and armed flag;
// buffer contents are not cleared. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module msb_first_bit_reader
    import msbr_pkg::*;
#(
    parameter int BUFFER_BYTES  = BUFFER_BYTES_DEF,
    parameter int MAX_READ_BITS = MAX_READ_BITS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  msbr_cmd_t    cmd,
    output logic         busy,
    output logic         done,
    output msbr_result_t result
);

    localparam int POS_W = ($clog2(BUFFER_BYTES * 8 + 1) > 12) ?
                           $clog2(BUFFER_BYTES * 8 + 1) : 12;
    localparam int AW    = $clog2(BUFFER_BYTES);

    state_t           state_reg, state_next;
    msbr_cmd_t        cmd_reg;
    logic [POS_W-1:0] pos_reg;
    logic [8:0]       limit_reg;
    logic             armed_reg;
    status_t          status_reg;
    logic [63:0]      value_reg, value_next;

    logic [AW-1:0]    addr_reg;
    logic [3:0]       iss_left_reg;
    logic [3:0]       rcv_left_reg;
    logic             data_vld_reg;
    logic             first_reg;
    logic [2:0]       off_reg;
    logic [2:0]       drop_reg;
    logic [71:0]      acc_reg;
    logic [71:0]      acc_next;

    logic [7:0]       mem [BUFFER_BYTES];
    logic [7:0]       rdata_reg;
    logic [31:0]      waddr_x;

    msbr_ctrl_t       ctrl;
    logic [POS_W-1:0] new_pos;
    logic             accept;
    logic             in_eval;
    logic             rd_en;
    logic             last_byte;
    logic [6:0]       span;
    logic [2:0]       tail;
    logic [7:0]       fmask;

    msbr_eval #(
        .BUFFER_BYTES  (BUFFER_BYTES),
        .MAX_READ_BITS (MAX_READ_BITS),
        .POS_W         (POS_W)
    ) u_eval (
        .cmd     (cmd_reg),
        .pos     (pos_reg),
        .limit   (limit_reg),
        .armed   (armed_reg),
        .ctrl    (ctrl),
        .new_pos (new_pos)
    );

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                    state_next = S_EVAL;
            end
            S_EVAL:
            begin
                state_next = ctrl.read_go ? S_READ : S_DONE;
            end
            S_READ:
            begin
                if (last_byte)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy    = 1'b1;
        done    = 1'b0;
        in_eval = 1'b0;
        rd_en   = 1'b0;
        case (state_reg)
            S_IDLE: busy = 1'b0;
            S_EVAL: in_eval = 1'b1;
            S_READ: rd_en = (iss_left_reg != '0);
            S_DONE: done = 1'b1;
            default: busy = 1'b1;
        endcase
    end

    assign accept    = start && !busy;
    assign last_byte = data_vld_reg && (rcv_left_reg == 4'd1);

    // byte count and trailing bits to drop for a read
    assign span = 7'({4'b0, pos_reg[2:0]}) + cmd_reg.amount[6:0] + 7'd7;
    assign tail = pos_reg[2:0] + cmd_reg.amount[2:0];

    // clear the leading bits of the first byte, then shift bytes in
    assign fmask    = first_reg ? (8'hFF >> off_reg) : 8'hFF;
    assign acc_next = {acc_reg[63:0], rdata_reg & fmask};

    always_comb
    begin
        value_next = value_reg;
        if (in_eval)
            value_next = '0;
        else if (last_byte)
            value_next = 64'(acc_next >> drop_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            pos_reg      <= '0;
            limit_reg    <= '0;
            armed_reg    <= 1'b0;
            iss_left_reg <= '0;
            rcv_left_reg <= '0;
            data_vld_reg <= 1'b0;
            first_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            data_vld_reg <= rd_en;
            if (in_eval)
            begin
                if (ctrl.restart)
                begin
                    limit_reg <= cmd_reg.region_size;
                    armed_reg <= 1'b1;
                end
                if (ctrl.pos_load)
                    pos_reg <= new_pos;
                iss_left_reg <= span[6:3];
                rcv_left_reg <= span[6:3];
                first_reg    <= 1'b1;
            end
            else
            begin
                if (rd_en)
                    iss_left_reg <= iss_left_reg - 4'd1;
                if (data_vld_reg)
                begin
                    rcv_left_reg <= rcv_left_reg - 4'd1;
                    first_reg    <= 1'b0;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
            cmd_reg <= cmd;
        value_reg <= value_next;
        if (in_eval)
        begin
            status_reg <= ctrl.status;
            addr_reg   <= pos_reg[AW+2:3];
            off_reg    <= pos_reg[2:0];
            drop_reg   <= 3'd0 - tail;
            acc_reg    <= '0;
        end
        else
        begin
            if (rd_en)
                addr_reg <= addr_reg + AW'(1);
            if (data_vld_reg)
                acc_reg <= acc_next;
        end
    end

    // ---------------- byte buffer ----------------
    assign waddr_x = 32'(cmd_reg.write_address);

    always_ff @(posedge clk)
    begin
        if (in_eval && ctrl.write_en)
            mem[waddr_x[AW-1:0]] <= cmd_reg.write_byte;
        if (rd_en)
            rdata_reg <= mem[addr_reg];
    end

    assign result.bits_value = value_reg;
    assign result.byte_index = 9'(pos_reg >> 3);
    assign result.status     = status_reg;

    // ---------------- assertions ----------------
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("item accepted but block not busy next cycle");

    a_done_release: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy && !done)
        else $error("block did not release after result");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status_reg != ST_OK) |-> (value_reg == '0))
        else $error("failed item returned nonzero bits");

    a_fetch_in_read: assert property (@(posedge clk) disable iff (!rst_n)
        data_vld_reg |-> (state_reg == S_READ) && (rcv_left_reg != '0))
        else $error("buffer byte returned outside a read");

    a_fetch_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> (iss_left_reg <= rcv_left_reg))
        else $error("byte fetches ran ahead of count");

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Regression for msb_first_bit_reader. A scoreboard keeps its own copy of
// the byte store, bit position, region end and armed flag and predicts
// every result. A short directed run covers the unarmed case, the status
// codes, zero-size moves and the exact region end. Random sessions follow:
// fill a window, restart on it, then read and skip through it. Random idle
// gaps fall between the items.
// ----------------------------------------------------------------------------
module tb
    import msbr_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned STORE_BYTES = BUFFER_BYTES_DEF;
    localparam int unsigned WIDEST_READ = MAX_READ_BITS_DEF;
    localparam int unsigned TARGET_ITEMS = 650;

    class read_scoreboard;
        logic [7:0]   store [STORE_BYTES];
        int unsigned  pos;
        int unsigned  region_end;
        bit           armed;
        msbr_result_t pending_results [$];
        int unsigned  failures;

        function new();
            pos = 0;
            region_end = 0;
            armed = 1'b0;
            failures = 0;
        endfunction

        function int unsigned end_bits();
            return ((region_end > STORE_BYTES) ? STORE_BYTES : region_end) * 8;
        endfunction

        // Apply one accepted item to the shadow state and queue its result
        function void take_cmd(msbr_cmd_t c);
            msbr_result_t exp_res;
            logic [63:0]  value;
            status_t      st;
            int unsigned  next_byte;
            int unsigned  p;
            value = '0;
            st = ST_OK;
            case (c.action)
                ACT_WRITE: store[c.write_address] = c.write_byte;
                ACT_RESTART:
                begin
                    pos = c.start_byte * 8;
                    region_end = c.region_size;
                    armed = 1'b1;
                end
                ACT_READ, ACT_SKIP_BITS, ACT_SKIP_BYTES:
                begin
                    if (!armed)
                        st = ST_NOT_ARMED;
                    else if (c.action == ACT_READ)
                    begin
                        if (c.amount > WIDEST_READ)
                            st = ST_TOO_WIDE;
                        else if (pos + c.amount > end_bits())
                            st = ST_BOUNDS;
                        else
                        begin
                            for (int unsigned i = 0; i < c.amount; i++)
                            begin
                                p = pos + i;
                                value = {value[62:0], store[p >> 3][7 - (p & 7)]};
                            end
                            pos += c.amount;
                        end
                    end
                    else if (c.action == ACT_SKIP_BITS)
                    begin
                        if (pos + c.amount > end_bits())
                            st = ST_BOUNDS;
                        else
                            pos += c.amount;
                    end
                    else
                    begin
                        // round up to a byte boundary, then add whole bytes
                        next_byte = ((pos + 7) >> 3) + c.amount;
                        if (next_byte * 8 > end_bits())
                            st = ST_BOUNDS;
                        else
                            pos = next_byte * 8;
                    end
                end
                default: ;
            endcase
            exp_res.bits_value = value;
            exp_res.byte_index = 9'(pos >> 3);
            exp_res.status = st;
            pending_results.push_back(exp_res);
        endfunction

        function void check_result(msbr_result_t r);
            msbr_result_t exp_res;
            if (pending_results.size() == 0)
            begin
                $error("result with no item pending: value %h index %0d status %0d",
                       r.bits_value, r.byte_index, r.status);
                failures++;
                return;
            end
            exp_res = pending_results.pop_front();
            if (r.bits_value !== exp_res.bits_value)
            begin
                $error("bits_value: expected %h, got %h", exp_res.bits_value, r.bits_value);
                failures++;
            end
            if (r.byte_index !== exp_res.byte_index)
            begin
                $error("byte_index: expected %0d, got %0d", exp_res.byte_index,
                       r.byte_index);
                failures++;
            end
            if (r.status !== exp_res.status)
            begin
                $error("status: expected %0d, got %0d", exp_res.status, r.status);
                failures++;
            end
        endfunction
    endclass

    logic         clk = 1'b0;
    logic         rst_n;
    logic         start;
    msbr_cmd_t    cmd;
    logic         busy;
    logic         done;
    msbr_result_t result;

    read_scoreboard board;
    bit             byte_loaded [STORE_BYTES];
    int unsigned    commands_issued = 0;
    int unsigned    calm_left = 0;

    msb_first_bit_reader DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (done === 1'b1)
            board.check_result(result);
    end

    initial
    begin
        #2_000_000;
        $display("msb_first_bit_reader regression: fail");
        $finish;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4)
        begin
            calm_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Fields that the action does not use still carry random values
    function automatic msbr_cmd_t make_cmd(logic [2:0] act);
        msbr_cmd_t c;
        c.action = act;
        c.write_address = 8'($urandom);
        c.write_byte = 8'($urandom);
        c.start_byte = 9'($urandom);
        c.region_size = 9'($urandom);
        c.amount = 12'($urandom);
        return c;
    endfunction

    task automatic issue(msbr_cmd_t c);
        int unsigned gap;
        start <= 1'b1;
        cmd <= c;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        board.take_cmd(c);
        if (c.action == ACT_WRITE)
            byte_loaded[c.write_address] = 1'b1;
        if (c.action <= ACT_SKIP_BYTES)
            commands_issued++;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_byte_at(int unsigned addr, int unsigned data);
        msbr_cmd_t c;
        c = make_cmd(ACT_WRITE);
        c.write_address = 8'(addr);
        c.write_byte = 8'(data);
        issue(c);
    endtask

    task automatic restart_at(int unsigned first_byte, int unsigned end_byte);
        msbr_cmd_t c;
        c = make_cmd(ACT_RESTART);
        c.start_byte = 9'(first_byte);
        c.region_size = 9'(end_byte);
        issue(c);
    endtask

    task automatic move(logic [2:0] act, int unsigned amount);
        msbr_cmd_t   c;
        int unsigned last_byte;
        // a read that will succeed must only touch loaded bytes
        if (act == ACT_READ && board.armed && amount > 0 && amount <= WIDEST_READ
            && board.pos + amount <= board.end_bits())
        begin
            last_byte = (board.pos + amount - 1) >> 3;
            for (int unsigned b = board.pos >> 3; b <= last_byte; b++)
            begin
                if (!byte_loaded[b])
                    write_byte_at(b, $urandom_range(0, 255));
            end
        end
        c = make_cmd(act);
        c.amount = 12'(amount);
        issue(c);
    endtask

    function automatic int unsigned read_size(int unsigned room);
        int unsigned r;
        int unsigned cap;
        cap = (room > WIDEST_READ) ? WIDEST_READ : room;
        r = $urandom_range(0, 99);
        if (r < 60)
            return (cap == 0) ? $urandom_range(0, 8) : $urandom_range(1, cap);
        if (r < 75)
            return cap;
        if (r < 85)
            return $urandom_range(0, WIDEST_READ);
        if (r < 93)
            return room + $urandom_range(1, 8);
        return $urandom_range(WIDEST_READ + 1, 4095);
    endfunction

    function automatic int unsigned skip_size(int unsigned room);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return $urandom_range(0, (room > 32) ? 32 : room);
        if (r < 70)
            return room;
        if (r < 85)
            return room + $urandom_range(1, 16);
        return $urandom_range(0, 4095);
    endfunction

    initial
    begin
        int unsigned base;
        int unsigned span;
        int unsigned room;
        int unsigned r;
        int unsigned count;
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        board = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // nothing armed yet; unused codes do nothing
        move(ACT_READ, 8);
        move(ACT_SKIP_BITS, 3);
        move(ACT_SKIP_BYTES, 1);
        move(3'd5, 0);
        move(3'd7, 4095);

        write_byte_at(0, 8'hFF);
        write_byte_at(1, 8'h00);
        write_byte_at(2, 8'hA5);
        write_byte_at(3, 8'h5A);
        write_byte_at(4, 8'h80);
        write_byte_at(5, 8'h01);
        write_byte_at(6, 8'hC3);
        write_byte_at(7, 8'h3C);
        write_byte_at(8, 8'h7E);
        write_byte_at(255, 8'hFF);

        restart_at(0, 9);
        move(ACT_READ, 0);
        move(ACT_READ, WIDEST_READ + 1);
        move(ACT_READ, 1);
        move(ACT_READ, WIDEST_READ);
        // rounds up to the exact region end
        move(ACT_SKIP_BYTES, 0);
        move(ACT_READ, 1);
        move(ACT_SKIP_BITS, 0);

        // region past the buffer clamps to the buffer end
        restart_at(255, 511);
        move(ACT_READ, 8);
        move(ACT_SKIP_BITS, 1);
        move(ACT_SKIP_BYTES, 0);

        // start beyond the end
        restart_at(511, 0);
        move(ACT_SKIP_BITS, 4095);
        move(ACT_SKIP_BYTES, 4095);

        while (commands_issued < TARGET_ITEMS)
        begin
            base = $urandom_range(0, STORE_BYTES - 1);
            span = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 24)
                                                : $urandom_range(0, STORE_BYTES - base);
            if (span > 0)
            begin
                count = $urandom_range(0, span);
                for (int unsigned k = 0; k < count; k++)
                    write_byte_at(base + $urandom_range(0, span - 1), $urandom_range(0, 255));
            end
            r = $urandom_range(0, 99);
            if (r < 80)
                restart_at(base, base + span);
            else if (r < 90)
                restart_at(base, $urandom_range(0, 511));
            else
                restart_at($urandom_range(0, 511), $urandom_range(0, 511));

            count = $urandom_range(3, 16);
            for (int unsigned k = 0; k < count; k++)
            begin
                room = (board.end_bits() > board.pos) ? board.end_bits() - board.pos : 0;
                r = $urandom_range(0, 99);
                if (r < 50)
                    move(ACT_READ, read_size(room));
                else if (r < 70)
                    move(ACT_SKIP_BITS, skip_size(room));
                else if (r < 82)
                    move(ACT_SKIP_BYTES, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095)
                                                                     : $urandom_range(0, 3));
                else if (r < 90)
                    write_byte_at($urandom_range(0, 255), $urandom_range(0, 255));
                else if (r < 95)
                    move(3'($urandom_range(5, 7)), $urandom_range(0, 4095));
                else
                    restart_at($urandom_range(0, 511), $urandom_range(0, 511));
            end
        end

        start <= 1'b0;
        while (board.pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (board.failures == 0 && board.pending_results.size() == 0)
            $display("msb_first_bit_reader regression: pass");
        else
            $display("msb_first_bit_reader regression: fail");
        $finish;
    end

endmodule

// File: files.f
design/msbr_pkg.sv
design/msbr_eval.sv
design/msb_first_bit_reader.sv
tb/tb.sv
